// ===== rtl/triangle_scanline_span_core_assert.svh =====
// ----------------------------------------------------------------------------
// Triangle scanline span core assertion macros
// Concurrent assertion wrappers with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SCANLINE_SPAN_CORE_ASSERT_SVH
`define TRIANGLE_SCANLINE_SPAN_CORE_ASSERT_SVH

// check prop on every clock edge outside reset
`define TSS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// check prop on every clock edge, reset included
`define TSS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span package
// Widths, request and result types, and register indexes.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int MAX_DIM = 4096;
  localparam int CW      = 16;
  localparam int RW      = 12;
  localparam int DW      = 13;
  localparam int HALF    = 16384;
  localparam int PW      = 30;
  localparam int NW      = 2 * PW;
  localparam int SUBW    = 15;
  localparam int DENW    = PW + SUBW;
  localparam int QW      = 13;
  localparam int OFS     = 1 << (QW - 2);
  localparam int OFSH    = SUBW + QW - 2;
  localparam int FW      = 15;
  localparam int IW      = 2;

  localparam logic [IW-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [IW-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [CW-1:0] vertex_a_x;
    logic signed [CW-1:0] vertex_a_y;
    logic signed [CW-1:0] vertex_b_x;
    logic signed [CW-1:0] vertex_b_y;
    logic signed [CW-1:0] vertex_c_x;
    logic signed [CW-1:0] vertex_c_y;
    logic [RW-1:0]        row;
  } in_t;

  typedef struct packed {
    logic          covered;
    logic [RW-1:0] span_first;
    logic [RW-1:0] span_last;
  } out_t;

  typedef struct packed {
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] y;
  } pt_t;

  typedef struct packed {
    logic signed [PW-1:0] xa;
    logic signed [PW-1:0] dy;
    logic signed [PW-1:0] dx;
    logic signed [PW-1:0] t;
  } edge_t;

endpackage

// ===== rtl/tss_setup.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span setup
// Maps vertices to pixel space, sorts them by y and picks both edges.
// ----------------------------------------------------------------------------
module tss_setup (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  tss_pkg::in_t          in_item,
  input  logic [tss_pkg::DW-1:0] width,
  input  logic [tss_pkg::DW-1:0] height,
  output logic                  valid,
  output logic                  ok,
  output tss_pkg::edge_t        long_edge,
  output tss_pkg::edge_t        short_edge
);
  import tss_pkg::*;

  function automatic logic signed [PW-1:0] map_coord(logic signed [CW-1:0] c,
                                                     logic [DW-1:0] s);
    logic signed [CW:0]      o;
    logic signed [CW+DW+1:0] pr;
    o  = $signed({c[CW-1], c}) + $signed((CW+1)'(HALF));
    pr = o * $signed({1'b0, s});
    return pr[PW-1:0];
  endfunction

  function automatic logic later(pt_t a, pt_t b);
    return (a.y > b.y) || ((a.y == b.y) && (a.x > b.x));
  endfunction

  logic          v0, v1, v2, v3, v4;
  in_t           it0;
  logic [RW-1:0] row1, row2, row3, row4;
  pt_t           p1 [3];
  pt_t           p2 [3];
  pt_t           p3 [3];
  pt_t           p4 [3];
  pt_t           m  [3];
  pt_t           s1 [3];
  pt_t           s2 [3];
  pt_t           s3 [3];
  logic signed [PW-1:0] y4;
  logic          hit;

  always_comb begin
    m[0].x = map_coord(it0.vertex_a_x, width);
    m[0].y = map_coord(it0.vertex_a_y, height);
    m[1].x = map_coord(it0.vertex_b_x, width);
    m[1].y = map_coord(it0.vertex_b_y, height);
    m[2].x = map_coord(it0.vertex_c_x, width);
    m[2].y = map_coord(it0.vertex_c_y, height);
  end

  always_comb begin
    s1 = p1;
    if (later(p1[0], p1[1])) begin
      s1[0] = p1[1];
      s1[1] = p1[0];
    end
    s2 = p2;
    if (later(p2[1], p2[2])) begin
      s2[1] = p2[2];
      s2[2] = p2[1];
    end
    s3 = p3;
    if (later(p3[0], p3[1])) begin
      s3[0] = p3[1];
      s3[1] = p3[0];
    end
  end

  assign y4  = $signed({{(PW-RW-SUBW){1'b0}}, row4, {SUBW{1'b0}}});
  assign hit = ({1'b0, row4} < height) && (y4 >= p4[0].y) && (y4 < p4[2].y);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v0    <= in_valid;
      v1    <= v0;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0  <= in_item;
      p1   <= m;
      row1 <= it0.row;
      p2   <= s1;
      row2 <= row1;
      p3   <= s2;
      row3 <= row2;
      p4   <= s3;
      row4 <= row3;
      ok   <= hit;
      long_edge.xa <= p4[0].x;
      long_edge.dy <= p4[2].y - p4[0].y;
      long_edge.dx <= p4[2].x - p4[0].x;
      long_edge.t  <= y4 - p4[0].y;
      if (y4 < p4[1].y) begin
        short_edge.xa <= p4[0].x;
        short_edge.dy <= p4[1].y - p4[0].y;
        short_edge.dx <= p4[1].x - p4[0].x;
        short_edge.t  <= y4 - p4[0].y;
      end else begin
        short_edge.xa <= p4[1].x;
        short_edge.dy <= p4[2].y - p4[1].y;
        short_edge.dx <= p4[2].x - p4[1].x;
        short_edge.t  <= y4 - p4[1].y;
      end
    end
  end

endmodule

// ===== rtl/tss_edge_mul.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span edge multiply
// Forms the crossing numerator, offset to stay positive, and its denominator.
// ----------------------------------------------------------------------------
module tss_edge_mul (
  input  logic                     clk,
  input  logic                     en,
  input  tss_pkg::edge_t           edge_in,
  output logic [tss_pkg::NW-1:0]   num,
  output logic [tss_pkg::DENW-1:0] den
);
  import tss_pkg::*;

  logic signed [NW-1:0] prod_a, prod_b, bias, sum;
  logic signed [PW-1:0] dy1;

  assign bias = $signed({{(NW-PW-OFSH){dy1[PW-1]}}, dy1, {OFSH{1'b0}}});
  assign sum  = prod_a + prod_b + bias;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= edge_in.xa * edge_in.dy;
      prod_b <= edge_in.dx * edge_in.t;
      dy1    <= edge_in.dy;
      num    <= sum;
      den    <= {dy1, {SUBW{1'b0}}};
    end
  end

endmodule

// ===== rtl/tss_divider.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span divider
// Pipelined restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tss_divider (
  input  logic                     clk,
  input  logic                     en,
  input  logic [tss_pkg::NW-1:0]   num,
  input  logic [tss_pkg::DENW-1:0] den,
  output logic [tss_pkg::QW-1:0]   quot,
  output logic                     exact
);
  import tss_pkg::*;

  logic [NW-1:0]   rem [QW];
  logic [QW-1:0]   qq  [QW];
  logic [DENW-1:0] dd  [QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int B = QW - 1 - s;
    logic [NW-1:0]   r_in;
    logic [DENW-1:0] d_in;
    logic [QW-1:0]   q_in;
    logic [NW:0]     shifted, diff;

    if (s == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem[s-1];
      assign d_in = dd[s-1];
      assign q_in = qq[s-1];
    end

    assign shifted = (NW+1)'(d_in) << B;
    assign diff    = {1'b0, r_in} - shifted;

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[NW]) begin
          rem[s] <= diff[NW-1:0];
          qq[s]  <= q_in | (QW'(1) << B);
        end else begin
          rem[s] <= r_in;
          qq[s]  <= q_in;
        end
      end
    end

    if (s < QW - 1) begin : g_d
      always_ff @(posedge clk) begin
        if (en) begin
          dd[s] <= d_in;
        end
      end
    end
  end

  assign quot  = qq[QW-1];
  assign exact = (rem[QW-1] == '0);

endmodule

// ===== rtl/tss_span.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span bounds
// Turns both crossings into an inclusive column span clipped to the image.
// ----------------------------------------------------------------------------
module tss_span (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic                   ok,
  input  logic [tss_pkg::QW-1:0] q_long,
  input  logic                   ex_long,
  input  logic [tss_pkg::QW-1:0] q_short,
  input  logic                   ex_short,
  input  logic [tss_pkg::DW-1:0] width,
  output logic                   valid,
  output tss_pkg::out_t          item
);
  import tss_pkg::*;

  logic                 v1, ok1;
  logic signed [FW-1:0] f1, c1, f2, c2, lo, hi, lo1, hi1, wm1, first, last;
  logic                 cov;

  assign f1 = $signed(FW'(q_long)) - $signed(FW'(OFS));
  assign c1 = f1 + $signed(FW'(!ex_long));
  assign f2 = $signed(FW'(q_short)) - $signed(FW'(OFS));
  assign c2 = f2 + $signed(FW'(!ex_short));
  assign lo = (c1 < c2) ? c1 : c2;
  assign hi = (f1 > f2) ? f1 : f2;

  assign wm1   = $signed(FW'(width)) - $signed(FW'(1));
  assign first = (lo1 < 0) ? '0 : lo1;
  assign last  = (hi1 > wm1) ? wm1 : hi1;
  assign cov   = ok1 && (first <= last);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok1             <= ok;
      lo1             <= lo;
      hi1             <= hi;
      item.covered    <= cov;
      item.span_first <= cov ? first[RW-1:0] : '0;
      item.span_last  <= cov ? last[RW-1:0] : '0;
    end
  end

endmodule

// ===== rtl/triangle_scanline_span_core.sv =====
// Pipeline: 6 setup, 2 multiply, 13 divider and 2 span register stages
// lie between request acceptance and result.
// Throughput: one request per cycle while in_stall is low; the one-bit-per-stage
// divider lines of both edges run fully pipelined.
// Reset: synchronous, clears all valid bits and the output skid register,
// and sets image width and height to 512.
// ----------------------------------------------------------------------------
// Triangle scanline span core
// Covered pixel span of one row of a triangle, one request per cycle when not stalled.
// ----------------------------------------------------------------------------
module triangle_scanline_span_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tss_pkg::in_t           in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tss_pkg::out_t          out_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [tss_pkg::IW-1:0] cfg_index,
  input  logic [tss_pkg::DW-1:0] cfg_data
);
  import tss_pkg::*;

  localparam int DLY = 2 + QW;

  logic [DW-1:0]   image_width, image_height, wc, hc;
  logic            en;
  logic            sv5, ok5;
  edge_t           long_edge, short_edge;
  logic [NW-1:0]   num_l, num_s;
  logic [DENW-1:0] den_l, den_s;
  logic [QW-1:0]   q_l, q_s;
  logic            ex_l, ex_s;
  logic            dv [DLY];
  logic            dok [DLY];
  logic            lv;
  out_t            litem;
  logic            s_v;
  out_t            s_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DW'(512);
      image_height <= DW'(512);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wc = (image_width > DW'(MAX_DIM)) ? DW'(MAX_DIM) : image_width;
  assign hc = (image_height > DW'(MAX_DIM)) ? DW'(MAX_DIM) : image_height;

  assign en       = !s_v;
  assign in_stall = s_v;

  tss_setup u_setup (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .width      (wc),
    .height     (hc),
    .valid      (sv5),
    .ok         (ok5),
    .long_edge  (long_edge),
    .short_edge (short_edge)
  );

  tss_edge_mul u_mul_long (
    .clk     (clk),
    .en      (en),
    .edge_in (long_edge),
    .num     (num_l),
    .den     (den_l)
  );

  tss_edge_mul u_mul_short (
    .clk     (clk),
    .en      (en),
    .edge_in (short_edge),
    .num     (num_s),
    .den     (den_s)
  );

  tss_divider u_div_long (
    .clk   (clk),
    .en    (en),
    .num   (num_l),
    .den   (den_l),
    .quot  (q_l),
    .exact (ex_l)
  );

  tss_divider u_div_short (
    .clk   (clk),
    .en    (en),
    .num   (num_s),
    .den   (den_s),
    .quot  (q_s),
    .exact (ex_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DLY; i++) begin
        dv[i] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= sv5;
      for (int i = 1; i < DLY; i++) begin
        dv[i] <= dv[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dok[0] <= ok5;
      for (int i = 1; i < DLY; i++) begin
        dok[i] <= dok[i-1];
      end
    end
  end

  tss_span u_span (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (dv[DLY-1]),
    .ok       (dok[DLY-1]),
    .q_long   (q_l),
    .ex_long  (ex_l),
    .q_short  (q_s),
    .ex_short (ex_s),
    .width    (wc),
    .valid    (lv),
    .item     (litem)
  );

  // hold a stalled result aside so the pipeline still advances when the stall first appears
  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (s_v) begin
      if (!out_stall) begin
        s_v <= 1'b0;
      end
    end else if (lv && out_stall) begin
      s_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!s_v && lv && out_stall) begin
      s_item <= litem;
    end
  end

  assign out_valid = s_v || lv;
  assign out_item  = s_v ? s_item : litem;

endmodule

// ===== rtl/tss_checker.sv =====
// ----------------------------------------------------------------------------
// Triangle scanline span port checker
// Watches the result channel of the core and reset behavior.
// ----------------------------------------------------------------------------
`include "triangle_scanline_span_core_assert.svh"

module tss_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input tss_pkg::out_t out_item
);
  import tss_pkg::*;

  `TSS_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_item), "stalled result changed")
  `TSS_ASSERT(a_empty_zero, clk, rst, out_valid && !out_item.covered |-> out_item.span_first == 0 && out_item.span_last == 0, "uncovered result has nonzero span")
  `TSS_ASSERT(a_span_order, clk, rst, out_valid && out_item.covered |-> out_item.span_first <= out_item.span_last, "span first beyond span last")
  `TSS_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid && !in_stall, "core not idle after reset")

endmodule

bind triangle_scanline_span_core tss_checker u_tss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
